[design/gww_pkg.sv]
// Shared types, constants and helpers for the greedy word wrap block.
package gww_pkg;

  localparam int MAX_PORTION = 30;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd80;

  localparam logic REG_LINE_LENGTH = 1'b0;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_P      = 8'd80;
  localparam logic [7:0] CH_HYPHEN = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] CH_EXCL   = 8'd33;
  localparam logic [7:0] CH_COLON  = 8'd58;

  typedef enum logic [1:0] {
    KIND_NOTHING,
    KIND_TEXT,
    KIND_BREAK
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SPACE,
    ST_CNL,
    ST_CHAR,
    ST_POST
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic       from_mem;
    logic [7:0] chr;
    logic       last;
    logic       status;
    logic       ovf;
  } op_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_QUEST) || (c == CH_EXCL) || (c == CH_COLON);
  endfunction

endpackage

[design/gww_regs.sv]
// APB configuration register holding the line length.
module gww_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  line_length
);

  logic [7:0] line_length_r;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == gww_pkg::REG_LINE_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= gww_pkg::LINE_LENGTH_RESET;
    end else if (wr_hit) begin
      line_length_r <= pwdata[7:0];
    end
  end

  assign prdata      = (paddr[2] == gww_pkg::REG_LINE_LENGTH) ? {24'd0, line_length_r} : 32'd0;
  assign line_length = line_length_r;

endmodule

[design/gww_mem.sv]
// Portion buffer: one write port, one registered read port.
module gww_mem #(
  parameter int MAX_PORTION = gww_pkg::MAX_PORTION,
  localparam int IDX_W = $clog2(MAX_PORTION)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem_r [MAX_PORTION];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/gww_ctrl.sv]
// Input decode, line state and the emit sequencer that walks the portion buffer.
module gww_ctrl #(
  parameter int MAX_PORTION = gww_pkg::MAX_PORTION,
  localparam int CNT_W = $clog2(MAX_PORTION + 1),
  localparam int IDX_W = $clog2(MAX_PORTION)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [7:0]       in_char_code,
  input  logic [7:0]       line_length,
  input  logic             op_ready,
  output gww_pkg::op_t     op,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output logic [7:0]       wr_data,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr
);

  gww_pkg::seq_state_t state_r, state_nxt;
  gww_pkg::kind_t      kind_r, kind_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       lp_r, lp_nxt;
  logic             punct_r, punct_nxt;
  logic             first_r, first_nxt;
  logic             long_r, long_nxt;
  logic             ovf_r, ovf_nxt;
  logic             tail_punct_r, tail_punct_nxt;
  logic             pp_ok_r, pp_ok_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             chunked_r, chunked_nxt;
  logic             post_r, post_nxt;
  logic             end_r, end_nxt;
  logic [1:0]       sp_r, sp_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [7:0]       col_r, col_nxt;

  logic [7:0]       len_eff;
  logic             acc;
  logic             is_sp;
  logic             is_hy;
  logic             text;
  logic             room;
  logic             store;
  logic [CNT_W-1:0] n_cand;
  logic             brk;
  logic             brk_nl;
  logic             flush;
  logic             post;
  logic [1:0]       spaces;
  logic [8:0]       fit_sum;
  logic             chunked;
  logic             last_char;
  logic [8:0]       col_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gww_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= gww_pkg::KIND_NOTHING;
      count_r      <= '0;
      lp_r         <= '0;
      punct_r      <= 1'b0;
      first_r      <= 1'b1;
      long_r       <= 1'b0;
      ovf_r        <= 1'b0;
      tail_punct_r <= 1'b0;
      pp_ok_r      <= 1'b0;
      chunked_r    <= 1'b0;
      post_r       <= 1'b0;
      end_r        <= 1'b0;
      sp_r         <= '0;
      j_r          <= '0;
      col_r        <= '0;
      n_r          <= '0;
    end else begin
      kind_r       <= kind_nxt;
      count_r      <= count_nxt;
      lp_r         <= lp_nxt;
      punct_r      <= punct_nxt;
      first_r      <= first_nxt;
      long_r       <= long_nxt;
      ovf_r        <= ovf_nxt;
      tail_punct_r <= tail_punct_nxt;
      pp_ok_r      <= pp_ok_nxt;
      chunked_r    <= chunked_nxt;
      post_r       <= post_nxt;
      end_r        <= end_nxt;
      sp_r         <= sp_nxt;
      j_r          <= j_nxt;
      col_r        <= col_nxt;
      n_r          <= n_nxt;
    end
  end

  always_comb begin
    len_eff  = (line_length == 8'd0) ? 8'd1 : line_length;
    acc      = in_valid && (state_r == gww_pkg::ST_IDLE);
    in_stall = (state_r != gww_pkg::ST_IDLE);

    is_sp  = gww_pkg::is_space(in_char_code);
    is_hy  = (in_char_code == gww_pkg::CH_HYPHEN);
    text   = !in_kind && !is_sp;
    room   = (count_r != CNT_W'(MAX_PORTION));
    store  = text && room;
    n_cand = count_r + CNT_W'(store);
    brk    = (in_kind || is_sp) && first_r && (count_r == CNT_W'(3)) && pp_ok_r;
    brk_nl = brk && (kind_r == gww_pkg::KIND_TEXT);
    flush  = (text && is_hy) || ((in_kind || is_sp) && (count_r != '0) && !brk);
    post   = in_kind && (flush || (!brk && (kind_r == gww_pkg::KIND_TEXT)));
    if (first_r && (kind_r == gww_pkg::KIND_TEXT)) begin
      spaces = punct_r ? 2'd2 : 2'd1;
    end else begin
      spaces = 2'd0;
    end
    fit_sum   = 9'(lp_r) + 9'(spaces) + 9'(n_cand);
    chunked   = (fit_sum > 9'(len_eff));
    last_char = (j_r == (n_r - CNT_W'(1)));
    col_inc   = 9'(col_r) + 9'd1;

    state_nxt      = state_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    lp_nxt         = lp_r;
    punct_nxt      = punct_r;
    first_nxt      = first_r;
    long_nxt       = long_r;
    ovf_nxt        = ovf_r;
    tail_punct_nxt = tail_punct_r;
    pp_ok_nxt      = pp_ok_r;
    chunked_nxt    = chunked_r;
    post_nxt       = post_r;
    end_nxt        = end_r;
    sp_nxt         = sp_r;
    j_nxt          = j_r;
    col_nxt        = col_r;
    n_nxt          = n_r;

    op        = '0;
    op.status = long_r;
    op.ovf    = ovf_r;
    wr_en     = 1'b0;
    wr_addr   = count_r[IDX_W-1:0];
    wr_data   = in_char_code;
    rd_en     = 1'b0;
    rd_addr   = j_r[IDX_W-1:0];

    case (state_r)
      gww_pkg::ST_IDLE: begin
        if (acc) begin
          if (text) begin
            if (room) begin
              wr_en          = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              tail_punct_nxt = gww_pkg::is_punct(in_char_code);
              if (count_r == CNT_W'(0)) begin
                pp_ok_nxt = (in_char_code == gww_pkg::CH_AT);
              end else if (count_r == CNT_W'(1)) begin
                pp_ok_nxt = pp_ok_r && (in_char_code == gww_pkg::CH_P);
              end else if (count_r == CNT_W'(2)) begin
                pp_ok_nxt = pp_ok_r && (in_char_code == gww_pkg::CH_AT);
              end
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (flush) begin
            count_nxt   = '0;
            kind_nxt    = gww_pkg::KIND_TEXT;
            punct_nxt   = store ? gww_pkg::is_punct(in_char_code) : tail_punct_r;
            long_nxt    = long_r || (9'(n_cand) > 9'(len_eff));
            if (!chunked) begin
              lp_nxt = fit_sum[7:0];
            end
            n_nxt       = n_cand;
            chunked_nxt = chunked;
            sp_nxt      = spaces;
            j_nxt       = '0;
            col_nxt     = '0;
          end
          if (brk) begin
            count_nxt = '0;
            if (kind_r == gww_pkg::KIND_TEXT) begin
              lp_nxt   = '0;
              kind_nxt = gww_pkg::KIND_BREAK;
            end
          end
          if (in_kind || is_sp) begin
            first_nxt = 1'b1;
          end else if (is_hy) begin
            first_nxt = 1'b0;
          end
          post_nxt = post;
          end_nxt  = in_kind;
          if (in_kind) begin
            count_nxt = '0;
            lp_nxt    = '0;
            kind_nxt  = gww_pkg::KIND_NOTHING;
            punct_nxt = 1'b0;
            first_nxt = 1'b1;
          end
          if (flush) begin
            if (kind_r == gww_pkg::KIND_BREAK) begin
              state_nxt = gww_pkg::ST_PRE;
            end else if (chunked) begin
              state_nxt = (lp_r == 8'd0) ? gww_pkg::ST_CHAR : gww_pkg::ST_CNL;
            end else begin
              state_nxt = (spaces != 2'd0) ? gww_pkg::ST_SPACE : gww_pkg::ST_CHAR;
            end
          end else if (post || brk_nl) begin
            state_nxt = gww_pkg::ST_POST;
          end
        end
      end
      gww_pkg::ST_PRE: begin
        if (op_ready) begin
          op.valid  = 1'b1;
          op.chr    = gww_pkg::CH_NL;
          state_nxt = gww_pkg::ST_CHAR;
        end
      end
      gww_pkg::ST_SPACE: begin
        if (op_ready) begin
          op.valid = 1'b1;
          op.chr   = gww_pkg::CH_SPACE;
          sp_nxt   = sp_r - 2'd1;
          if (sp_r == 2'd1) begin
            state_nxt = gww_pkg::ST_CHAR;
          end
        end
      end
      gww_pkg::ST_CNL: begin
        if (op_ready) begin
          op.valid  = 1'b1;
          op.chr    = gww_pkg::CH_NL;
          col_nxt   = '0;
          state_nxt = gww_pkg::ST_CHAR;
        end
      end
      gww_pkg::ST_CHAR: begin
        if (op_ready) begin
          op.valid    = 1'b1;
          op.from_mem = 1'b1;
          op.last     = last_char && !post_r;
          rd_en       = 1'b1;
          j_nxt       = j_r + CNT_W'(1);
          col_nxt     = col_inc[7:0];
          if (last_char) begin
            if (chunked_r && !end_r) begin
              lp_nxt = col_inc[7:0];
            end
            state_nxt = post_r ? gww_pkg::ST_POST : gww_pkg::ST_IDLE;
          end else if (chunked_r && (col_inc == 9'(len_eff))) begin
            state_nxt = gww_pkg::ST_CNL;
          end
        end
      end
      gww_pkg::ST_POST: begin
        if (op_ready) begin
          op.valid  = 1'b1;
          op.chr    = gww_pkg::CH_NL;
          op.last   = 1'b1;
          state_nxt = gww_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gww_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/gww_out.sv]
// Read-data alignment stage and output register of the result channel.
module gww_out (
  input  logic         clk,
  input  logic         rst_n,
  input  gww_pkg::op_t op,
  output logic         op_ready,
  input  logic [7:0]   rd_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_out_char,
  output logic         out_last_of_run,
  output logic         out_status,
  output logic         out_overflow
);

  gww_pkg::op_t p_op_r;
  logic         p_valid_r, p_valid_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   char_r;
  logic         last_r;
  logic         status_r;
  logic         ovf_r;
  logic         p_move;

  always_comb begin
    p_move   = p_valid_r && (!out_valid_r || !out_stall);
    op_ready = !p_valid_r || p_move;

    p_valid_nxt = p_valid_r;
    if (op_ready) begin
      p_valid_nxt = op.valid;
    end

    out_valid_nxt = out_valid_r;
    if (p_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op.valid) begin
      p_op_r <= op;
    end
    if (p_move) begin
      char_r   <= p_op_r.from_mem ? rd_data : p_op_r.chr;
      last_r   <= p_op_r.last;
      status_r <= p_op_r.status;
      ovf_r    <= p_op_r.ovf;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_char    = char_r;
  assign out_last_of_run = last_r;
  assign out_status      = status_r;
  assign out_overflow    = ovf_r;

endmodule

[design/greedy_word_wrap.sv]
// Greedy word wrap top level: register port, controller, portion buffer and output stage.
// Text bytes that only extend the pending portion are taken one per cycle while idle. A byte
// that flushes a portion (hyphen, whitespace, end of input) holds in_stall while the
// sequencer issues the result words it causes, one word per cycle while the output stage
// is ready, through the single read port of the portion buffer. A break token that ends a
// line, or a lone final newline, holds in_stall while its newline is issued; a break that
// collapses into an earlier one, like any byte with no result, does not stall. The portion
// buffer needs no clearing after reset. line_length may only be written while no input
// word is pending.
module greedy_word_wrap #(
  parameter int MAX_PORTION = gww_pkg::MAX_PORTION
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_char,
  output logic        out_last_of_run,
  output logic        out_status,
  output logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_PORTION);

  logic [7:0]       line_length;
  gww_pkg::op_t     op;
  logic             op_ready;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  gww_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .line_length (line_length)
  );

  gww_mem #(
    .MAX_PORTION (MAX_PORTION)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gww_ctrl #(
    .MAX_PORTION (MAX_PORTION)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .line_length  (line_length),
    .op_ready     (op_ready),
    .op           (op),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  gww_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .op_ready        (op_ready),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_char    (out_out_char),
    .out_last_of_run (out_last_of_run),
    .out_status      (out_status),
    .out_overflow    (out_overflow)
  );

`ifndef SYNTHESIS
  a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !op.valid)
    else $error("word issued while controller idle");

  a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    op.valid |-> op_ready)
    else $error("word issued into a full output stage");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |=> (!out_valid || out_status))
    else $error("status flag dropped without reset");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |=> (!out_valid || out_overflow))
    else $error("overflow flag dropped without reset");
`endif

endmodule
